FILE: src/shtq_pkg.sv
// ----------------------------------------------------------------------------
// shtq_pkg
// Shared constants and types of the quadratic-probe string hash table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package shtq_pkg;
    localparam int TABLE_DEPTH   = 1024;
    localparam int MAX_KEY_CHARS = 20;
    localparam int SLOT_W  = $clog2(TABLE_DEPTH);
    localparam int SIZE_W  = SLOT_W + 1;
    localparam int CHAR_W  = 8;
    localparam int LEN_W   = $clog2(MAX_KEY_CHARS + 2);
    localparam int KPOS_W  = (MAX_KEY_CHARS > 1) ? $clog2(MAX_KEY_CHARS) : 1;
    localparam int KEY_W   = MAX_KEY_CHARS * CHAR_W;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOTFND  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_TOOLONG = 2'd3;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic [0:0] REG_MULT = 1'b0;
    localparam logic [0:0] REG_SIZE = 1'b1;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
    } shtq_result_t;
endpackage

FILE: src/shtq_mod.sv
// ----------------------------------------------------------------------------
// shtq_mod
// Sequential remainder of a 32-bit hash by the table size, one bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module shtq_mod
    import shtq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [31:0]       dividend,
    input  logic [SIZE_W-1:0] divisor,
    output logic              done,
    output logic [SLOT_W-1:0] remainder
);
    logic [31:0]       quo_reg;
    logic [SIZE_W:0]   rem_reg;
    logic [5:0]        cnt_reg;
    logic              busy_reg;
    logic [SIZE_W:0]   trial;

    assign trial = {rem_reg[SIZE_W-1:0], quo_reg[31]};
    assign remainder = rem_reg[SLOT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[30:0], 1'b0};
            if (trial >= {1'b0, divisor})
                rem_reg <= trial - {1'b0, divisor};
            else
                rem_reg <= trial;
        end
    end
endmodule

FILE: src/string_hash_table_quadratic_probe.sv
// ----------------------------------------------------------------------------
// string_hash_table_quadratic_probe
// Open-addressing table of short text keys with triangular probing.
// ----------------------------------------------------------------------------
// A non-final character is taken while idle. A final character starts the
// bit-serial remainder, then each probe has a memory read, then a compare and
// step, up to table_size probes; the result is offered in the next cycle and
// held until taken. An over-long key gives its result in the cycle after its
// final character. One key is in work at a time. After reset a clearing pass
// empties the valid marks of all slots.
`timescale 1ns / 1ps
module string_hash_table_quadratic_probe
    import shtq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              cmd,
    input  logic [7:0]        key_char,
    input  logic              key_last,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [9:0]        slot_index,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;
    localparam logic [2:0] S_CLR  = 3'd5;

    logic [31:0]       mult_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [2:0]        state_reg;
    logic [31:0]       hash_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [KEY_W-1:0]  key_reg;
    logic              cmd_reg;
    logic              mod_start_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [SIZE_W-1:0] step_reg;
    logic [SIZE_W-1:0] count_reg;
    logic [SLOT_W-1:0] clr_reg;
    logic [SIZE_W-1:0] used_size;
    logic              mod_done;
    logic [SLOT_W-1:0] mod_rem;
    logic              mem_vld [TABLE_DEPTH];
    logic [KEY_W-1:0]  mem_key [TABLE_DEPTH];
    logic [LEN_W-1:0]  mem_len [TABLE_DEPTH];
    logic [KEY_W-1:0]  rd_key_reg;
    logic [LEN_W-1:0]  rd_len_reg;
    logic              rd_valid_reg;
    logic              wr_en;
    logic [KEY_W-1:0]  key_next;
    logic [31:0]       hash_next;
    logic [SIZE_W:0]   idx_sum;
    logic [SLOT_W-1:0] idx_next;
    logic              in_take;
    logic              mtch;

    assign used_size = (size_reg == '0) ? SIZE_W'(1) :
                       (size_reg > SIZE_W'(TABLE_DEPTH)) ? SIZE_W'(TABLE_DEPTH) : size_reg;
    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg <= 32'd31;
            size_reg <= SIZE_W'(TABLE_DEPTH);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MULT: mult_reg <= cfg_data;
                REG_SIZE: size_reg <= cfg_data[SIZE_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        key_next = key_reg;
        if (len_reg < LEN_W'(MAX_KEY_CHARS))
            key_next[len_reg[KPOS_W-1:0]*CHAR_W +: CHAR_W] = key_char;
        hash_next = (len_reg == '0) ? {24'd0, key_char} : hash_reg * mult_reg + {24'd0, key_char};
    end

    shtq_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start_reg),
        .dividend  (hash_reg),
        .divisor   (used_size),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // A stored key matches when lengths agree and every used character agrees.
    always_comb
    begin
        mtch = (rd_len_reg == len_reg);
        for (int k = 0; k < MAX_KEY_CHARS; k++)
            if (LEN_W'(k) < len_reg &&
                rd_key_reg[k*CHAR_W +: CHAR_W] != key_reg[k*CHAR_W +: CHAR_W])
                mtch = 1'b0;
    end

    assign idx_sum  = {2'b0, idx_reg} + {1'b0, step_reg};
    assign idx_next = (idx_sum >= {1'b0, used_size}) ?
                      SLOT_W'(idx_sum - {1'b0, used_size}) : idx_sum[SLOT_W-1:0];
    assign wr_en = (state_reg == S_CMP) && !rd_valid_reg && (cmd_reg == CMD_INSERT);

    always_ff @(posedge clk)
    begin
        rd_key_reg   <= mem_key[idx_reg];
        rd_len_reg   <= mem_len[idx_reg];
        rd_valid_reg <= mem_vld[idx_reg];
        if (state_reg == S_CLR)
            mem_vld[clr_reg] <= 1'b0;
        else if (wr_en)
            mem_vld[idx_reg] <= 1'b1;
        if (wr_en)
        begin
            mem_key[idx_reg] <= key_reg;
            mem_len[idx_reg] <= len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            hash_reg      <= '0;
            len_reg       <= '0;
            key_reg       <= '0;
            cmd_reg       <= CMD_INSERT;
            idx_reg       <= '0;
            step_reg      <= '0;
            count_reg     <= '0;
            status        <= ST_OK;
            slot_index    <= '0;
            out_valid     <= 1'b0;
            mod_start_reg <= 1'b0;
        end
        else
        begin
            mod_start_reg <= 1'b0;
            case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + SLOT_W'(1);
                    if (clr_reg == SLOT_W'(TABLE_DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        hash_reg <= hash_next;
                        key_reg  <= key_next;
                        cmd_reg  <= cmd;
                        len_reg  <= (len_reg < LEN_W'(MAX_KEY_CHARS)) ?
                                    len_reg + LEN_W'(1) : LEN_W'(MAX_KEY_CHARS + 1);
                        if (key_last)
                        begin
                            if (len_reg >= LEN_W'(MAX_KEY_CHARS))
                            begin
                                status     <= ST_TOOLONG;
                                slot_index <= '0;
                                out_valid  <= 1'b1;
                                state_reg  <= S_OUT;
                            end
                            else
                            begin
                                mod_start_reg <= 1'b1;
                                state_reg     <= S_MOD;
                            end
                        end
                    end
                end
                S_MOD:
                begin
                    if (mod_done)
                    begin
                        idx_reg   <= mod_rem;
                        step_reg  <= SIZE_W'(1);
                        count_reg <= '0;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (!rd_valid_reg)
                    begin
                        if (cmd_reg == CMD_INSERT)
                        begin
                            status     <= ST_OK;
                            slot_index <= idx_reg;
                        end
                        else
                        begin
                            status     <= ST_NOTFND;
                            slot_index <= '0;
                        end
                        out_valid <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else if (cmd_reg == CMD_SEARCH && mtch)
                    begin
                        status     <= ST_OK;
                        slot_index <= idx_reg;
                        out_valid  <= 1'b1;
                        state_reg  <= S_OUT;
                    end
                    else if (count_reg + SIZE_W'(1) >= used_size)
                    begin
                        status     <= ST_FULL;
                        slot_index <= '0;
                        out_valid  <= 1'b1;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        // Triangular step: offset grows by i+1 each probe.
                        idx_reg   <= idx_next;
                        step_reg  <= (step_reg + SIZE_W'(1) >= used_size) ?
                                     step_reg + SIZE_W'(1) - used_size : step_reg + SIZE_W'(1);
                        count_reg <= count_reg + SIZE_W'(1);
                        state_reg <= S_RD;
                    end
                end
                S_OUT:
                begin
                    hash_reg <= '0;
                    len_reg  <= '0;
                    if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
